// ----- rtl/pmt_pkg.sv -----
// Shared types, codes and constants for the paged MMU translate block.
package pmt_pkg;

  localparam int NUM_PAGES = 16;
  localparam int PAGE_W    = 4;

  typedef enum logic [1:0] {
    CMD_TRANSLATE = 2'd0,
    CMD_REG_READ  = 2'd1,
    CMD_REG_WRITE = 2'd2,
    CMD_SR0_WRITE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RDONLY = 3'd1,
    ST_NOACC  = 3'd2,
    ST_LENGTH = 3'd3,
    ST_BUS    = 3'd4
  } status_t;

  // Bus address bits 17:4 of each page register bank.
  localparam logic [13:0] KDESC_BANK = 14'o37514;
  localparam logic [13:0] KBASE_BANK = 14'o37516;
  localparam logic [13:0] UDESC_BANK = 14'o37770;
  localparam logic [13:0] UBASE_BANK = 14'o37772;

  localparam logic [15:0] IO_WINDOW_TOP = 16'o167777;
  localparam logic [18:0] IO_PAGE_OFS   = 19'o600000;
  localparam logic [15:0] WRITTEN_BIT   = 16'h0040;

  typedef struct packed {
    cmd_t        cmd;
    logic [17:0] address;
    logic        is_write;
    logic        user_mode;
    logic [15:0] prog_counter;
    logic [15:0] write_data;
  } item_t;

  typedef struct packed {
    logic              desc_we;
    logic              base_we;
    logic [PAGE_W-1:0] slot;
    logic [15:0]       data;
  } page_upd_t;

  typedef struct packed {
    logic        sr0_we;
    logic [15:0] sr0;
    logic        sr2_we;
    logic [15:0] sr2;
  } sr_upd_t;

  typedef struct packed {
    status_t     status;
    logic [18:0] phys_addr;
    logic [15:0] read_data;
  } result_t;

endpackage

// ----- rtl/paged_mmu_translate.sv -----
// Top level of the paged MMU: input register, page registers, status registers, result register.
//
// Usage: a command beat (cmd, address, is_write, user_mode, prog_counter,
// write_data) is taken at a rising edge where start is high and busy is low.
// Busy is low except while rst is held, so one beat can be taken every cycle.
// The beat is captured in an input register; in the next cycle the page
// lookup, access checks and relocation run in one pass, and at the end of
// that cycle the result register, the page registers and the status
// registers are all updated together. So done rises at the edge after the
// accepting one and stays high for exactly one cycle per beat. Throughput
// is one beat per cycle, set by the read-modify-write of the page register
// file in one pass. A beat always sees every state change of the beat
// before it. status_zero and status_two show the status registers after
// the beat marked by done. The receiver cannot stall: each result is shown
// once and must be taken in that cycle. Reset (synchronous) clears all page
// registers, both status registers and any beat in flight.
module paged_mmu_translate #(
  parameter int NUM_PAGES = pmt_pkg::NUM_PAGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [17:0] address,
  input  logic        is_write,
  input  logic        user_mode,
  input  logic [15:0] prog_counter,
  input  logic [15:0] write_data,
  output logic        done,
  output logic [2:0]  result_status,
  output logic [18:0] phys_addr,
  output logic [15:0] read_data,
  output logic [15:0] status_zero,
  output logic [15:0] status_two
);

  pmt_pkg::item_t                item;
  logic                          item_valid;
  logic [15:0]                   sr0;
  logic [15:0]                   sr2;
  logic [15:0]                   rd_desc;
  logic [15:0]                   rd_base;
  logic [pmt_pkg::PAGE_W-1:0]    rd_slot;
  pmt_pkg::page_upd_t            page_upd;
  pmt_pkg::page_upd_t            page_upd_gated;
  pmt_pkg::sr_upd_t              sr_upd;
  pmt_pkg::result_t              result_next;
  pmt_pkg::result_t              result;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item <= '{cmd: pmt_pkg::cmd_t'(cmd), address: address, is_write: is_write,
                user_mode: user_mode, prog_counter: prog_counter,
                write_data: write_data};
    end
  end

  pmt_translate u_translate (
    .item     (item),
    .sr0_cur  (sr0),
    .rd_desc  (rd_desc),
    .rd_base  (rd_base),
    .rd_slot  (rd_slot),
    .page_upd (page_upd),
    .sr_upd   (sr_upd),
    .result   (result_next)
  );

  always_comb begin
    page_upd_gated         = page_upd;
    page_upd_gated.desc_we = page_upd.desc_we & item_valid;
    page_upd_gated.base_we = page_upd.base_we & item_valid;
  end

  pmt_page_regs #(
    .NUM_PAGES (NUM_PAGES)
  ) u_page_regs (
    .clk     (clk),
    .rst     (rst),
    .upd     (page_upd_gated),
    .rd_slot (rd_slot),
    .rd_desc (rd_desc),
    .rd_base (rd_base)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sr0  <= '0;
      sr2  <= '0;
      done <= 1'b0;
    end else begin
      done <= item_valid;
      if (item_valid && sr_upd.sr0_we) begin
        sr0 <= sr_upd.sr0;
      end
      if (item_valid && sr_upd.sr2_we) begin
        sr2 <= sr_upd.sr2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      result <= result_next;
    end
  end

  assign result_status = result.status;
  assign phys_addr     = result.phys_addr;
  assign read_data     = result.read_data;
  assign status_zero   = sr0;
  assign status_two    = sr2;

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    item_valid |=> done)
    else $error("beat in the input register did not produce a result");

  a_fault_no_phys: assert property (@(posedge clk) disable iff (rst)
    done && (result_status != pmt_pkg::ST_OK) |-> phys_addr == 19'd0)
    else $error("faulting beat carries a physical address");

  a_bus_err_quiet: assert property (@(posedge clk) disable iff (rst)
    done && (result_status == pmt_pkg::ST_BUS) |-> $stable(status_zero) && $stable(status_two))
    else $error("bus error changed a status register");

  a_rdonly_record: assert property (@(posedge clk) disable iff (rst)
    done && (result_status == pmt_pkg::ST_RDONLY) |-> status_zero[13] && status_zero[0])
    else $error("read-only fault not recorded in status 0");
`endif

endmodule

// ----- rtl/pmt_page_regs.sv -----
// Descriptor and base registers for all pages, one update port and one read port.
module pmt_page_regs #(
  parameter int NUM_PAGES = pmt_pkg::NUM_PAGES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pmt_pkg::page_upd_t        upd,
  input  logic [pmt_pkg::PAGE_W-1:0] rd_slot,
  output logic [15:0]               rd_desc,
  output logic [15:0]               rd_base
);

  logic [15:0] desc [NUM_PAGES];
  logic [15:0] base [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PAGES; i++) begin
        desc[i] <= '0;
        base[i] <= '0;
      end
    end else begin
      if (upd.desc_we) begin
        desc[upd.slot] <= upd.data;
      end
      if (upd.base_we) begin
        base[upd.slot] <= upd.data;
      end
    end
  end

  assign rd_desc = desc[rd_slot];
  assign rd_base = base[rd_slot];

endmodule

// ----- rtl/pmt_translate.sv -----
// Single-pass decode, access checks and address relocation for one beat.
module pmt_translate (
  input  pmt_pkg::item_t             item,
  input  logic [15:0]                sr0_cur,
  input  logic [15:0]                rd_desc,
  input  logic [15:0]                rd_base,
  output logic [pmt_pkg::PAGE_W-1:0] rd_slot,
  output pmt_pkg::page_upd_t         page_upd,
  output pmt_pkg::sr_upd_t           sr_upd,
  output pmt_pkg::result_t           result
);

  logic [15:0] va;
  logic [6:0]  block;
  logic [5:0]  disp;
  logic [6:0]  len;
  logic        over;
  logic [12:0] frame;
  logic        hit_kdesc, hit_kbase, hit_udesc, hit_ubase, reg_hit, reg_is_base;
  logic [15:0] fault_word;

  assign va    = item.address[15:0];
  assign block = va[12:6];
  assign disp  = va[5:0];
  assign len   = rd_desc[14:8];
  assign over  = rd_desc[3] ? (block < len) : (block > len);
  assign frame = 13'(block) + 13'(rd_base[11:0]);

  assign hit_kdesc   = item.address[17:4] == pmt_pkg::KDESC_BANK;
  assign hit_kbase   = item.address[17:4] == pmt_pkg::KBASE_BANK;
  assign hit_udesc   = item.address[17:4] == pmt_pkg::UDESC_BANK;
  assign hit_ubase   = item.address[17:4] == pmt_pkg::UBASE_BANK;
  assign reg_hit     = hit_kdesc | hit_kbase | hit_udesc | hit_ubase;
  assign reg_is_base = hit_kbase | hit_ubase;

  // Fault word without the kind bit; the kind is or-ed in per fault.
  assign fault_word = {9'd0, item.user_mode, item.user_mode, 1'b0, va[15:13], 1'b1};

  always_comb begin
    rd_slot  = (item.cmd == pmt_pkg::CMD_TRANSLATE) ? {item.user_mode, va[15:13]}
                                                    : {hit_udesc | hit_ubase,
                                                       item.address[3:1]};
    page_upd = '{desc_we: 1'b0, base_we: 1'b0, slot: rd_slot, data: item.write_data};
    sr_upd   = '{sr0_we: 1'b0, sr0: item.write_data, sr2_we: 1'b0,
                 sr2: item.prog_counter};
    result   = '{status: pmt_pkg::ST_OK, phys_addr: '0, read_data: '0};
    unique case (item.cmd)
      pmt_pkg::CMD_TRANSLATE: begin
        if (sr0_cur[0]) begin
          priority if (item.is_write && (rd_desc[2:1] == 2'b00)) begin
            result.status = pmt_pkg::ST_RDONLY;
            sr_upd.sr0_we = 1'b1;
            sr_upd.sr2_we = 1'b1;
            sr_upd.sr0    = fault_word | 16'h2000;
          end else if (!rd_desc[1]) begin
            result.status = pmt_pkg::ST_NOACC;
            sr_upd.sr0_we = 1'b1;
            sr_upd.sr2_we = 1'b1;
            sr_upd.sr0    = fault_word | 16'h8000;
          end else if (over) begin
            result.status = pmt_pkg::ST_LENGTH;
            sr_upd.sr0_we = 1'b1;
            sr_upd.sr2_we = 1'b1;
            sr_upd.sr0    = fault_word | 16'h4000;
          end else begin
            result.phys_addr = {frame, disp};
            page_upd.desc_we = item.is_write;
            page_upd.data    = rd_desc | pmt_pkg::WRITTEN_BIT;
          end
        end else begin
          result.phys_addr = (va > pmt_pkg::IO_WINDOW_TOP)
                             ? 19'(va) + pmt_pkg::IO_PAGE_OFS : 19'(va);
        end
      end
      pmt_pkg::CMD_REG_READ: begin
        if (reg_hit) begin
          result.read_data = reg_is_base ? rd_base : rd_desc;
        end else begin
          result.status = pmt_pkg::ST_BUS;
        end
      end
      pmt_pkg::CMD_REG_WRITE: begin
        if (reg_hit) begin
          page_upd.desc_we = !reg_is_base;
          page_upd.base_we = reg_is_base;
        end else begin
          result.status = pmt_pkg::ST_BUS;
        end
      end
      pmt_pkg::CMD_SR0_WRITE: begin
        sr_upd.sr0_we = 1'b1;
      end
      default: begin
        result.status = pmt_pkg::ST_OK;
      end
    endcase
  end

endmodule
